// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define IMC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("imc assertion failed");

// implication checked at every clock edge outside reset
`define IMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imc implication failed");

`endif

// File: rtl/imc_pkg.sv
// package: lattice sizes, item types and register indexes
`timescale 1ns / 1ps
`default_nettype none
package imc_pkg;

    localparam int MAX_SIDE  = 128;
    localparam int ROW_W     = $clog2(MAX_SIDE);
    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int HALF_COLS = MAX_SIDE / 2;
    localparam int HALF_W    = $clog2(HALF_COLS);
    localparam int PROB_BITS = 16;
    localparam int SUM_W     = 16;
    localparam int MAG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LOW  = 2'd2;

    // input item modes
    localparam logic MODE_REINIT = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [PROB_BITS-1:0] rand_req;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] site_row;
        logic [ROW_W-1:0] site_col;
        logic             flipped;
        logic             sweep_done;
        logic [MAG_W-1:0] abs_spin_sum;
    } t_out_item;

    // current visit position and what follows from it
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             odd;
        logic             done;
        logic [ROW_W-1:0] up_row;
    } t_site;

endpackage
`default_nettype wire

// File: rtl/ising_metropolis_checkerboard_unit.sv
// top level: metropolis update sequencer over two sublattice banks
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_in_item (mode, rand_req)
//  out      output     o_out_valid / i_out_stall o_out_item (site, flip, sum)
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  an update item goes through S_RD1 and S_RD2 to S_EVAL: the neighbor bank has one read port and
//  serves the up, middle and down rows in turn; the next item is taken in
//  the write-back state S_EVAL. a reinitialize item goes through S_INIT.
//  reset and reinitialize clear per-row valid bits at once, no clearing pass.
//  a full output register holds an update in write-back until it drains.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ising_metropolis_checkerboard_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire imc_pkg::t_in_item              i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output imc_pkg::t_out_item                  o_out_item,
    input  wire logic                           i_cfg_we,
    input  wire logic [imc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [imc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import imc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EVAL,
        S_INIT
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [SIDE_W-1:0]    r_side;
    logic [PROB_BITS-1:0] r_prob_high;
    logic [PROB_BITS-1:0] r_prob_low;
    logic [SIDE_W-1:0]    side_raw;
    logic [SIDE_W-1:0]    side_fixed;
    logic                 cfg_side;

    // control
    logic   out_free;
    logic   can_take;
    logic   accept;
    logic   start;
    logic   eval_fire;
    logic   init_fire;
    logic   clear;
    t_site  site;

    // item datapath
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_col;
    logic                 r_ph;
    logic                 r_done;
    logic [PROB_BITS-1:0] r_rand;
    logic [HALF_COLS-1:0] r_ctr_row;
    logic                 r_up;
    logic                 r_lf;
    logic                 r_rt;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                 r_out_valid;
    t_out_item            r_out_item;

    logic [SIDE_W-1:0]    col8;
    logic [SIDE_W-1:0]    row8;
    logic [SIDE_W-1:0]    lf_col8;
    logic [SIDE_W-1:0]    rt_col8;
    logic [SIDE_W-1:0]    dn_row8;
    logic [ROW_W-1:0]     dn_row;
    logic [HALF_W-1:0]    hc;
    logic [HALF_W-1:0]    lf_hc;
    logic [HALF_W-1:0]    rt_hc;
    logic                 spin;
    logic                 dn_bit;
    logic [2:0]           ones;
    logic [2:0]           agree;
    logic                 flip;
    logic signed [SUM_W-1:0] abs_val;
    logic [HALF_COLS-1:0] n_ctr_row;

    // bank ports
    logic                 rd_ph;
    logic                 nb_en;
    logic [ROW_W-1:0]     nb_addr;
    logic                 even_rd_en;
    logic                 odd_rd_en;
    logic [ROW_W-1:0]     even_rd_addr;
    logic [ROW_W-1:0]     odd_rd_addr;
    logic [HALF_COLS-1:0] even_data;
    logic [HALF_COLS-1:0] odd_data;
    logic [HALF_COLS-1:0] ctr_data;
    logic [HALF_COLS-1:0] nb_data;
    logic                 even_wr;
    logic                 odd_wr;

    // side length write: even, clamped to the lattice
    always_comb begin
        side_raw = {i_cfg_data[SIDE_W-1:1], 1'b0};
        if (side_raw < SIDE_W'(2)) begin
            side_fixed = SIDE_W'(2);
        end else if (side_raw > SIDE_W'(MAX_SIDE)) begin
            side_fixed = SIDE_W'(MAX_SIDE);
        end else begin
            side_fixed = side_raw;
        end
    end

    assign cfg_side = i_cfg_we && (i_cfg_idx == CFG_SIDE_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_W'(16);
            r_prob_high <= '0;
            r_prob_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE_LENGTH: r_side      <= side_fixed;
                CFG_ACCEPT_HIGH: r_prob_high <= i_cfg_data[PROB_BITS-1:0];
                CFG_ACCEPT_LOW:  r_prob_low  <= i_cfg_data[PROB_BITS-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free  = !r_out_valid || !i_out_stall;
    assign can_take  = (r_state == S_IDLE) || ((r_state == S_EVAL) && out_free);
    assign o_in_stall = !can_take;
    assign accept    = i_in_valid && can_take;
    assign start     = accept && (i_in_item.mode == MODE_UPDATE);
    assign eval_fire = (r_state == S_EVAL) && out_free;
    assign init_fire = (r_state == S_INIT) && out_free;
    assign clear     = init_fire || cfg_side;

    imc_visit u_visit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (clear),
        .i_advance (start),
        .i_side    (r_side),
        .o_site    (site)
    );

    // neighbor addresses of the item in flight
    always_comb begin
        col8    = {1'b0, r_col};
        row8    = {1'b0, r_row};
        lf_col8 = (r_col == '0) ? r_side - SIDE_W'(1) : col8 - SIDE_W'(1);
        rt_col8 = (col8 + SIDE_W'(1) == r_side) ? '0 : col8 + SIDE_W'(1);
        dn_row8 = (row8 + SIDE_W'(1) == r_side) ? '0 : row8 + SIDE_W'(1);
        dn_row  = dn_row8[ROW_W-1:0];
        hc      = r_col[ROW_W-1:1];
        lf_hc   = lf_col8[ROW_W-1:1];
        rt_hc   = rt_col8[ROW_W-1:1];
    end

    // bank read steering: center bank once, neighbor bank up, middle, down
    always_comb begin
        rd_ph   = start ? site.odd : r_ph;
        nb_en   = start || (r_state == S_RD1) || (r_state == S_RD2);
        nb_addr = start ? site.up_row : ((r_state == S_RD1) ? r_row : dn_row);
        even_rd_en   = rd_ph ? nb_en : start;
        even_rd_addr = rd_ph ? nb_addr : site.row;
        odd_rd_en    = rd_ph ? start : nb_en;
        odd_rd_addr  = rd_ph ? site.row : nb_addr;
        ctr_data     = r_ph ? odd_data : even_data;
        nb_data      = r_ph ? even_data : odd_data;
        even_wr      = eval_fire && !r_ph;
        odd_wr       = eval_fire && r_ph;
    end

    imc_bank u_bank_even (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fill    (1'b1),
        .i_clear   (clear),
        .i_rd_en   (even_rd_en),
        .i_rd_addr (even_rd_addr),
        .o_rd_data (even_data),
        .i_wr_en   (even_wr),
        .i_wr_addr (r_row),
        .i_wr_data (n_ctr_row)
    );

    imc_bank u_bank_odd (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fill    (1'b0),
        .i_clear   (clear),
        .i_rd_en   (odd_rd_en),
        .i_rd_addr (odd_rd_addr),
        .o_rd_data (odd_data),
        .i_wr_en   (odd_wr),
        .i_wr_addr (r_row),
        .i_wr_data (n_ctr_row)
    );

    // metropolis decision: count neighbors that agree with the site
    always_comb begin
        spin   = r_ctr_row[hc];
        dn_bit = nb_data[hc];
        ones   = 3'(r_up) + 3'(r_lf) + 3'(r_rt) + 3'(dn_bit);
        agree  = spin ? ones : 3'd4 - ones;
        if (agree == 3'd4) begin
            flip = r_rand <= r_prob_high;
        end else if (agree == 3'd3) begin
            flip = r_rand <= r_prob_low;
        end else begin
            flip = 1'b1;
        end
        n_ctr_row = r_ctr_row ^ (HALF_COLS'(flip) << hc);
        if (!flip) begin
            n_sum = r_sum;
        end else if (spin) begin
            n_sum = r_sum - SUM_W'(2);
        end else begin
            n_sum = r_sum + SUM_W'(2);
        end
        abs_val = n_sum[SUM_W-1] ? -n_sum : n_sum;
    end

    // item datapath registers
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row  <= site.row;
            r_col  <= site.col;
            r_ph   <= site.odd;
            r_done <= site.done;
            r_rand <= i_in_item.rand_req;
        end
        if (r_state == S_RD1) begin
            r_ctr_row <= ctr_data;
            r_up      <= nb_data[hc];
        end
        if (r_state == S_RD2) begin
            r_lf <= nb_data[lf_hc];
            r_rt <= nb_data[rt_hc];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_EVAL: begin
                if (accept) begin
                    n_state = (i_in_item.mode == MODE_UPDATE) ? S_RD1 : S_INIT;
                end else if (eval_fire) begin
                    n_state = S_IDLE;
                end
            end
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_EVAL;
            S_INIT: n_state = out_free ? S_IDLE : S_INIT;
            default: n_state = S_IDLE;
        endcase
    end

    // state, spin sum and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clear) begin
                r_sum <= '0;
            end else if (eval_fire) begin
                r_sum <= n_sum;
            end
            if (eval_fire) begin
                r_out_valid             <= 1'b1;
                r_out_item.site_row     <= r_row;
                r_out_item.site_col     <= r_col;
                r_out_item.flipped      <= flip;
                r_out_item.sweep_done   <= r_done;
                r_out_item.abs_spin_sum <= abs_val[MAG_W-1:0];
            end else if (init_fire) begin
                r_out_valid <= 1'b1;
                r_out_item  <= '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    `IMC_ASSERT_IMPL(a_no_write_on_clear, i_clk, i_rst_n, even_wr || odd_wr, !clear)
    `IMC_ASSERT(a_update_path, i_clk, i_rst_n, (i_rst_n && start) |=> (r_state == S_RD1) ##1 (r_state == S_RD2) ##1 (r_state == S_EVAL))
    `IMC_ASSERT(a_sum_even, i_clk, i_rst_n, !r_sum[0])
    `IMC_ASSERT(a_visit_in_side, i_clk, i_rst_n, ({1'b0, site.row} < r_side) && ({1'b0, site.col} < r_side))

endmodule
`default_nettype wire

// File: rtl/imc_bank.sv
// one sublattice bank: row memory with per-row valid bits
`timescale 1ns / 1ps
`default_nettype none
module imc_bank (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fill,
    input  wire logic                        i_clear,
    input  wire logic                        i_rd_en,
    input  wire logic [imc_pkg::ROW_W-1:0]   i_rd_addr,
    output logic [imc_pkg::HALF_COLS-1:0]    o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic [imc_pkg::ROW_W-1:0]   i_wr_addr,
    input  wire logic [imc_pkg::HALF_COLS-1:0] i_wr_data
);
    import imc_pkg::*;

    logic [HALF_COLS-1:0] mem [MAX_SIDE];
    logic [MAX_SIDE-1:0]  r_valid;
    logic [HALF_COLS-1:0] r_rdata;
    logic                 r_rvalid;
    logic                 bypass;

    assign bypass = i_wr_en && (i_wr_addr == i_rd_addr);

    // row storage, write first on a same-row read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= bypass ? i_wr_data : mem[i_rd_addr];
        end
    end

    // row valid bits, an unwritten row reads as the checkerboard fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvalid <= r_valid[i_rd_addr] || bypass;
            end
        end
    end

    assign o_rd_data = r_rvalid ? r_rdata : {HALF_COLS{i_fill}};

endmodule
`default_nettype wire

// File: rtl/imc_visit.sv
// checkerboard visit order: position counter and its wraps
`timescale 1ns / 1ps
`default_nettype none
module imc_visit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_advance,
    input  wire logic [imc_pkg::SIDE_W-1:0] i_side,
    output imc_pkg::t_site                  o_site
);
    import imc_pkg::*;

    logic [ROW_W-1:0]  r_row, n_row;
    logic [ROW_W-1:0]  r_col, n_col;
    logic              r_odd, n_odd;
    logic [SIDE_W-1:0] col_step;
    logic [SIDE_W-1:0] row_step;
    logic [SIDE_W-1:0] side_m1;
    logic              wrap_c;
    logic              wrap_r;
    logic [ROW_W-1:0]  nr;

    // next site: two columns on, else next row, else other sublattice
    always_comb begin
        col_step = {1'b0, r_col} + SIDE_W'(2);
        row_step = {1'b0, r_row} + SIDE_W'(1);
        side_m1  = i_side - SIDE_W'(1);
        wrap_c   = col_step >= i_side;
        wrap_r   = row_step >= i_side;
        nr       = wrap_r ? '0 : row_step[ROW_W-1:0];
        n_odd    = (wrap_c && wrap_r) ? !r_odd : r_odd;
        n_row    = wrap_c ? nr : r_row;
        n_col    = wrap_c ? {{(ROW_W-1){1'b0}}, nr[0] ^ n_odd} : col_step[ROW_W-1:0];
    end

    always_comb begin
        o_site.row    = r_row;
        o_site.col    = r_col;
        o_site.odd    = r_odd;
        o_site.done   = wrap_c && wrap_r && r_odd;
        o_site.up_row = (r_row == '0) ? side_m1[ROW_W-1:0] : r_row - ROW_W'(1);
    end

    // position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_row <= '0;
            r_col <= '0;
            r_odd <= 1'b0;
        end else if (i_advance) begin
            r_row <= n_row;
            r_col <= n_col;
            r_odd <= n_odd;
        end
    end

endmodule
`default_nettype wire
